// ----- design/tct_pkg.sv -----
// ----------------------------------------------------------------------------
// tct_pkg: shared types and constants for the touch coordinate transform
// Field widths, register indexes, reset values and divider request/response
// structs used by the interfaces, the divider and the top level.
// ----------------------------------------------------------------------------
package tct_pkg;

  // field and register widths
  localparam int RAW_W  = 12;           // raw touch sample
  localparam int CFG_W  = 14;           // widest configuration register
  localparam int FB_W   = 13;           // framebuffer size register
  localparam int ORI_W  = 3;            // orientation register
  localparam int SCR_W  = 12;           // screen coordinate
  localparam int IDX_W  = 3;            // register index

  // datapath widths
  localparam int DIFF_W = 15;           // raw - min
  localparam int SPAN_W = 15;           // max - min
  localparam int PROD_W = 28;           // (raw - min) * fb_size, signed
  localparam int NUM_W  = PROD_W - 1;   // dividend magnitude
  localparam int DEN_W  = SPAN_W - 1;   // divisor magnitude
  localparam int QS_W   = NUM_W + 1;    // signed quotient
  localparam int POS_W  = QS_W + 1;     // quotient after mirroring

  // divider shape: quotient bits resolved per pipeline stage
  localparam int DIV_BITS   = 3;
  localparam int DIV_STAGES = NUM_W / DIV_BITS;

  // default screen size
  localparam int DEF_SCREEN_WIDTH  = 800;
  localparam int DEF_SCREEN_HEIGHT = 480;

  // register reset values
  localparam logic signed [CFG_W-1:0] X_MIN_RST  = 14'sd0;
  localparam logic signed [CFG_W-1:0] X_MAX_RST  = 14'sd4095;
  localparam logic signed [CFG_W-1:0] Y_MIN_RST  = 14'sd0;
  localparam logic signed [CFG_W-1:0] Y_MAX_RST  = 14'sd4095;
  localparam logic [FB_W-1:0]         FB_W_RST   = 13'd800;
  localparam logic [FB_W-1:0]         FB_H_RST   = 13'd480;
  localparam logic [ORI_W-1:0]        ORIENT_RST = 3'd0;

  // orientation bit positions
  localparam int ORI_ROT    = 0;
  localparam int ORI_FLIP_H = 1;
  localparam int ORI_FLIP_V = 2;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_X_MIN     = 3'd0,
    REG_X_MAX     = 3'd1,
    REG_Y_MIN     = 3'd2,
    REG_Y_MAX     = 3'd3,
    REG_FB_WIDTH  = 3'd4,
    REG_FB_HEIGHT = 3'd5,
    REG_ORIENT    = 3'd6
  } cfg_idx_t;

  // divider request: unsigned magnitudes and the sign of the quotient
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             neg;
  } div_req_t;

  // divider response: quotient magnitude and its sign
  typedef struct packed {
    logic [NUM_W-1:0] quo;
    logic             neg;
  } div_rsp_t;

endpackage

// ----- design/tct_in_if.sv -----
// ----------------------------------------------------------------------------
// tct_in_if: raw touch sample channel
// Valid/ready channel carrying one raw (x, y) sample per beat.
// ----------------------------------------------------------------------------
interface tct_in_if import tct_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_x;
  logic [RAW_W-1:0] raw_y;

  modport source (output valid, output raw_x, output raw_y, input ready);
  modport sink   (input valid, input raw_x, input raw_y, output ready);
endinterface

// ----- design/tct_out_if.sv -----
// ----------------------------------------------------------------------------
// tct_out_if: screen coordinate channel
// Valid/ready channel carrying one clamped screen position per beat.
// ----------------------------------------------------------------------------
interface tct_out_if import tct_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SCR_W-1:0] screen_x;
  logic [SCR_W-1:0] screen_y;
  logic             range_error;

  modport source (output valid, output screen_x, output screen_y, output range_error,
                  input ready);
  modport sink   (input valid, input screen_x, input screen_y, input range_error,
                  output ready);
endinterface

// ----- design/tct_div.sv -----
// ----------------------------------------------------------------------------
// tct_div: pipelined unsigned restoring divider
// Resolves DIV_BITS quotient bits per stage over DIV_STAGES stages; the whole
// pipe advances together under adv so a stall holds every stage in place.
// ----------------------------------------------------------------------------
module tct_div import tct_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  logic     req_vld,
  input  div_req_t req,
  output logic     rsp_vld,
  output div_rsp_t rsp
);

  logic [DIV_STAGES-1:0] vld_r;
  logic [DIV_STAGES-1:0] neg_r;
  logic [DEN_W-1:0]      rem_r [DIV_STAGES];
  logic [NUM_W-1:0]      nq_r  [DIV_STAGES];
  logic [DEN_W-1:0]      den_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] nq_in;
    logic [DEN_W-1:0] den_in;
    logic             vld_in;
    logic             neg_in;
    logic [DEN_W-1:0] rem_nxt;
    logic [NUM_W-1:0] nq_nxt;

    // select stage input: request for the first stage, previous stage after
    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = req.num;
      assign den_in = req.den;
      assign vld_in = req_vld;
      assign neg_in = req.neg;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign nq_in  = nq_r[s-1];
      assign den_in = den_r[s-1];
      assign vld_in = vld_r[s-1];
      assign neg_in = neg_r[s-1];
    end

    // shift in dividend bits, trial subtract, shift in quotient bits
    always_comb begin
      logic [DEN_W:0] trial;
      rem_nxt = rem_in;
      nq_nxt  = nq_in;
      for (int b = 0; b < DIV_BITS; b++) begin
        trial  = {rem_nxt, nq_nxt[NUM_W-1]};
        nq_nxt = {nq_nxt[NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, den_in}) begin
          trial     = trial - {1'b0, den_in};
          nq_nxt[0] = 1'b1;
        end
        rem_nxt = trial[DEN_W-1:0];
      end
    end

    // advance valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (adv) begin
        vld_r[s] <= vld_in;
      end
    end

    // advance payload
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s] <= rem_nxt;
        nq_r[s]  <= nq_nxt;
        den_r[s] <= den_in;
        neg_r[s] <= neg_in;
      end
    end
  end

  assign rsp_vld = vld_r[DIV_STAGES-1];
  assign rsp.quo = nq_r[DIV_STAGES-1];
  assign rsp.neg = neg_r[DIV_STAGES-1];

endmodule

// ----- design/touch_coordinate_transform_core.sv -----
// ----------------------------------------------------------------------------
// touch_coordinate_transform_core: raw touch sample to screen coordinates
// Linear calibration per axis, rotate and flip, clamp to the screen size.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries raw (raw_x, raw_y) beats, out_ch carries one beat of
//   (screen_x, screen_y, range_error) per input beat, in order.
//   The cfg_* port writes the calibration registers (index in cfg_index).
//   Write only while the block holds no sample in flight; it does not check.
// Pipeline: difference, multiply, magnitude, 9 divider stages of 3 quotient
//   bits each, sign, and the mirror/clamp output register.
// Throughput: one beat per cycle unless stalled; the divider sets stage count.
// Stall: when out_ch holds a beat that is not taken, the whole pipeline
//   holds and in_ch.ready drops in the same cycle; nothing is lost.
// Reset: rst_n low for one clock empties the pipeline and loads the default
//   calibration (span 0..4095, 800x480 framebuffer, no rotation).
// Zero span: when x_max equals x_min or y_max equals y_min the result is
//   (0, 0) with range_error set.
// ----------------------------------------------------------------------------
module touch_coordinate_transform_core import tct_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  tct_in_if.sink           in_ch,
  tct_out_if.source        out_ch
);

  localparam logic signed [POS_W-1:0] X_LIM = POS_W'(SCREEN_WIDTH);
  localparam logic signed [POS_W-1:0] Y_LIM = POS_W'(SCREEN_HEIGHT);

  // configuration registers
  logic signed [CFG_W-1:0] x_min_r;
  logic signed [CFG_W-1:0] x_max_r;
  logic signed [CFG_W-1:0] y_min_r;
  logic signed [CFG_W-1:0] y_max_r;
  logic [FB_W-1:0]         fb_width_r;
  logic [FB_W-1:0]         fb_height_r;
  logic [ORI_W-1:0]        orient_r;

  // pipeline control
  logic adv;

  // stage 0: raw - min
  logic                     s0_vld_r;
  logic signed [DIFF_W-1:0] s0_dx_r, s0_dy_r;
  logic signed [DIFF_W-1:0] dx_nxt, dy_nxt;

  // stage 1: scaled numerators
  logic                     s1_vld_r;
  logic signed [PROD_W-1:0] s1_px_r, s1_py_r;
  logic signed [PROD_W-1:0] px_nxt, py_nxt;

  // stage 2: divider requests
  logic                     s2_vld_r;
  div_req_t                 s2_x_r, s2_y_r;
  div_req_t                 req_x_nxt, req_y_nxt;
  logic signed [SPAN_W-1:0] span_x, span_y;

  // divider outputs
  logic     dx_vld, dy_vld;
  div_rsp_t rsp_x, rsp_y;

  // stage p1: signed quotients
  logic                   p1_vld_r;
  logic signed [QS_W-1:0] p1_qx_r, p1_qy_r;
  logic signed [QS_W-1:0] qx_nxt, qy_nxt;

  // output stage
  logic                    out_vld_r;
  logic [SCR_W-1:0]        out_x_r, out_y_r;
  logic                    out_err_r;
  logic signed [POS_W-1:0] fw_m1, fh_m1, ax, ay, sx_v, sy_v;
  logic                    zero_span;

  function automatic logic [SCR_W-1:0] clamp_pos(input logic signed [POS_W-1:0] v,
                                                 input logic signed [POS_W-1:0] lim);
    logic signed [POS_W-1:0] top;
    top = lim - POS_W'(1);
    if (v < 0) begin
      return '0;
    end else if (v >= lim) begin
      return top[SCR_W-1:0];
    end
    return v[SCR_W-1:0];
  endfunction

  // write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r     <= X_MIN_RST;
      x_max_r     <= X_MAX_RST;
      y_min_r     <= Y_MIN_RST;
      y_max_r     <= Y_MAX_RST;
      fb_width_r  <= FB_W_RST;
      fb_height_r <= FB_H_RST;
      orient_r    <= ORIENT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_X_MIN:     x_min_r     <= cfg_data;
        REG_X_MAX:     x_max_r     <= cfg_data;
        REG_Y_MIN:     y_min_r     <= cfg_data;
        REG_Y_MAX:     y_max_r     <= cfg_data;
        REG_FB_WIDTH:  fb_width_r  <= cfg_data[FB_W-1:0];
        REG_FB_HEIGHT: fb_height_r <= cfg_data[FB_W-1:0];
        REG_ORIENT:    orient_r    <= cfg_data[ORI_W-1:0];
        default: ;
      endcase
    end
  end

  // advance the whole pipe unless the output beat is held
  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 0: offset raw samples
  assign dx_nxt = DIFF_W'($signed({1'b0, in_ch.raw_x})) - DIFF_W'(x_min_r);
  assign dy_nxt = DIFF_W'($signed({1'b0, in_ch.raw_y})) - DIFF_W'(y_min_r);

  // stage 1: scale by framebuffer size
  assign px_nxt = PROD_W'(s0_dx_r) * PROD_W'($signed({1'b0, fb_width_r}));
  assign py_nxt = PROD_W'(s0_dy_r) * PROD_W'($signed({1'b0, fb_height_r}));

  // stage 2: split into magnitudes and quotient sign
  assign span_x = SPAN_W'(x_max_r) - SPAN_W'(x_min_r);
  assign span_y = SPAN_W'(y_max_r) - SPAN_W'(y_min_r);

  always_comb begin
    req_x_nxt.num = s1_px_r[PROD_W-1] ? NUM_W'(-s1_px_r) : s1_px_r[NUM_W-1:0];
    req_x_nxt.den = span_x[SPAN_W-1] ? DEN_W'(-span_x) : span_x[DEN_W-1:0];
    req_x_nxt.neg = s1_px_r[PROD_W-1] ^ span_x[SPAN_W-1];
    req_y_nxt.num = s1_py_r[PROD_W-1] ? NUM_W'(-s1_py_r) : s1_py_r[NUM_W-1:0];
    req_y_nxt.den = span_y[SPAN_W-1] ? DEN_W'(-span_y) : span_y[DEN_W-1:0];
    req_y_nxt.neg = s1_py_r[PROD_W-1] ^ span_y[SPAN_W-1];
  end

  // front stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_ch.valid;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
    end
  end

  // front stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_dx_r <= dx_nxt;
      s0_dy_r <= dy_nxt;
      s1_px_r <= px_nxt;
      s1_py_r <= py_nxt;
      s2_x_r  <= req_x_nxt;
      s2_y_r  <= req_y_nxt;
    end
  end

  // divide each axis
  tct_div u_div_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .req_vld (s2_vld_r),
    .req     (s2_x_r),
    .rsp_vld (dx_vld),
    .rsp     (rsp_x)
  );

  tct_div u_div_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .req_vld (s2_vld_r),
    .req     (s2_y_r),
    .rsp_vld (dy_vld),
    .rsp     (rsp_y)
  );

  // stage p1: restore quotient sign (truncation toward zero)
  always_comb begin
    qx_nxt = $signed({1'b0, rsp_x.quo});
    qy_nxt = $signed({1'b0, rsp_y.quo});
    if (rsp_x.neg) begin
      qx_nxt = -qx_nxt;
    end
    if (rsp_y.neg) begin
      qy_nxt = -qy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r <= dx_vld && dy_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_qx_r <= qx_nxt;
      p1_qy_r <= qy_nxt;
    end
  end

  // output stage: rotate, mirror, clamp
  assign fw_m1     = POS_W'($signed({1'b0, fb_width_r})) - POS_W'(1);
  assign fh_m1     = POS_W'($signed({1'b0, fb_height_r})) - POS_W'(1);
  assign ax        = POS_W'(p1_qx_r);
  assign ay        = POS_W'(p1_qy_r);
  assign zero_span = (x_max_r == x_min_r) || (y_max_r == y_min_r);

  always_comb begin
    if (orient_r[ORI_ROT]) begin
      sx_v = orient_r[ORI_FLIP_V] ? (fh_m1 - ay) : ay;
      sy_v = orient_r[ORI_FLIP_H] ? (fw_m1 - ax) : ax;
    end else begin
      sx_v = orient_r[ORI_FLIP_H] ? (fw_m1 - ax) : ax;
      sy_v = orient_r[ORI_FLIP_V] ? (fh_m1 - ay) : ay;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_r   <= zero_span ? '0 : clamp_pos(sx_v, X_LIM);
      out_y_r   <= zero_span ? '0 : clamp_pos(sy_v, Y_LIM);
      out_err_r <= zero_span;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.screen_x    = out_x_r;
  assign out_ch.screen_y    = out_y_r;
  assign out_ch.range_error = out_err_r;

  // range error forces the origin
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_err_r) |-> (out_x_r == '0) && (out_y_r == '0))
    else $error("range error beat with nonzero coordinates");

  // coordinates stay on screen
  a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ({1'b0, out_x_r} < (SCR_W+1)'(SCREEN_WIDTH)) &&
                  ({1'b0, out_y_r} < (SCR_W+1)'(SCREEN_HEIGHT)))
    else $error("output coordinate beyond screen size");

  // an accepted beat enters stage 0
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> s0_vld_r)
    else $error("accepted beat missing from stage 0");

  // a held output freezes the sign stage
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_vld_r && !adv) |=> p1_vld_r && $stable(p1_qx_r) && $stable(p1_qy_r))
    else $error("pipeline moved during stall");

  // both axis dividers stay in step
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    dx_vld == dy_vld)
    else $error("axis dividers out of step");

endmodule

// ----- verif/touch_pos_checker.sv -----
// ----------------------------------------------------------------------------
// touch_pos_checker: scoreboard for the touch coordinate transform
// Tracks calibration register writes and maps every accepted raw sample to
// the expected screen position. Each result beat is compared in order with
// the oldest expected position. Counts are handed to the testbench top.
// ----------------------------------------------------------------------------
module touch_pos_checker import tct_pkg::*; #(
  parameter int SCREEN_W = DEF_SCREEN_WIDTH,
  parameter int SCREEN_H = DEF_SCREEN_HEIGHT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  tct_in_if                in_mon,
  tct_out_if               out_mon,
  output int               fail_count,
  output int               pending_cnt,
  output int               checked_cnt,
  output int               span_err_cnt
);

  typedef struct packed {
    logic [SCR_W-1:0] screen_x;
    logic [SCR_W-1:0] screen_y;
    logic             range_error;
  } touch_pos_t;

  // shadow copy of the calibration registers
  logic signed [CFG_W-1:0] cal_x_min;
  logic signed [CFG_W-1:0] cal_x_max;
  logic signed [CFG_W-1:0] cal_y_min;
  logic signed [CFG_W-1:0] cal_y_max;
  logic [FB_W-1:0]         cal_fb_w;
  logic [FB_W-1:0]         cal_fb_h;
  logic [ORI_W-1:0]        cal_orient;

  touch_pos_t expected_pos_q[$];
  int         err_total   = 0;
  int         n_checked   = 0;
  int         n_span_err  = 0;

  function automatic logic [SCR_W-1:0] clamp_coord(longint v, longint lim);
    if (v < 0) return '0;
    if (v >= lim) return SCR_W'(lim - 1);
    return SCR_W'(v);
  endfunction

  // Scale both axes, apply rotate and flips, clamp to the screen.
  function automatic touch_pos_t map_sample(logic [RAW_W-1:0] rx, logic [RAW_W-1:0] ry);
    longint     xl, xh, yl, yh, fw, fh, px, py, sx, sy;
    touch_pos_t pos;
    xl = longint'(cal_x_min);
    xh = longint'(cal_x_max);
    yl = longint'(cal_y_min);
    yh = longint'(cal_y_max);
    fw = longint'(cal_fb_w);
    fh = longint'(cal_fb_h);
    // a zero span on either axis gives the origin with the error flag
    if (xh == xl || yh == yl) begin
      pos.screen_x    = '0;
      pos.screen_y    = '0;
      pos.range_error = 1'b1;
      return pos;
    end
    px = ((longint'(rx) - xl) * fw) / (xh - xl);
    py = ((longint'(ry) - yl) * fh) / (yh - yl);
    if (cal_orient[ORI_ROT]) begin
      sx = cal_orient[ORI_FLIP_V] ? (fh - 1) - py : py;
      sy = cal_orient[ORI_FLIP_H] ? (fw - 1) - px : px;
    end else begin
      sx = cal_orient[ORI_FLIP_H] ? (fw - 1) - px : px;
      sy = cal_orient[ORI_FLIP_V] ? (fh - 1) - py : py;
    end
    pos.screen_x    = clamp_coord(sx, SCREEN_W);
    pos.screen_y    = clamp_coord(sy, SCREEN_H);
    pos.range_error = 1'b0;
    return pos;
  endfunction

  always @(posedge clk) begin
    touch_pos_t want;
    if (!rst_n) begin
      cal_x_min  = X_MIN_RST;
      cal_x_max  = X_MAX_RST;
      cal_y_min  = Y_MIN_RST;
      cal_y_max  = Y_MAX_RST;
      cal_fb_w   = FB_W_RST;
      cal_fb_h   = FB_H_RST;
      cal_orient = ORIENT_RST;
      expected_pos_q.delete();
    end else begin
      // follow register writes; unknown indexes are dropped
      if (cfg_we) begin
        case (cfg_index)
          REG_X_MIN:     cal_x_min  = cfg_data;
          REG_X_MAX:     cal_x_max  = cfg_data;
          REG_Y_MIN:     cal_y_min  = cfg_data;
          REG_Y_MAX:     cal_y_max  = cfg_data;
          REG_FB_WIDTH:  cal_fb_w   = cfg_data[FB_W-1:0];
          REG_FB_HEIGHT: cal_fb_h   = cfg_data[FB_W-1:0];
          REG_ORIENT:    cal_orient = cfg_data[ORI_W-1:0];
          default: ;
        endcase
      end

      // predict on every input beat
      if (in_mon.valid && in_mon.ready)
        expected_pos_q.push_back(map_sample(in_mon.raw_x, in_mon.raw_y));

      // compare every result beat with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (expected_pos_q.size() == 0) begin
          err_total++;
          $display("%0t: unexpected result beat x=%0d y=%0d err=%0b", $time,
                   out_mon.screen_x, out_mon.screen_y, out_mon.range_error);
        end else begin
          want = expected_pos_q.pop_front();
          n_checked++;
          if (want.range_error) n_span_err++;
          if (out_mon.screen_x !== want.screen_x || out_mon.screen_y !== want.screen_y ||
              out_mon.range_error !== want.range_error) begin
            err_total++;
            $display("%0t: mismatch expected x=%0d y=%0d err=%0b, got x=%0d y=%0d err=%0b",
                     $time, want.screen_x, want.screen_y, want.range_error,
                     out_mon.screen_x, out_mon.screen_y, out_mon.range_error);
          end
        end
      end
    end
    fail_count   <= err_total;
    pending_cnt  <= expected_pos_q.size();
    checked_cnt  <= n_checked;
    span_err_cnt <= n_span_err;
  end

endmodule

// ----- verif/touch_coordinate_transform_core_tb.sv -----
// ----------------------------------------------------------------------------
// touch_coordinate_transform_core_tb: testbench top for the transform core
// Drives raw samples and calibration writes, idles both channels at random,
// and once holds the result side off long enough to back up the pipeline.
// A scoreboard beside the core predicts and checks every result beat.
// ----------------------------------------------------------------------------
module touch_coordinate_transform_core_tb;
  import tct_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int PIPE_LATENCY  = 14;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 46;
  localparam int HOLD_PHASE    = 5;
  localparam int HOLD_ITEMS    = 200;
  localparam int HOLD_CYCLES   = 400;
  // index past the last register; writes to it must be dropped
  localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct {
    logic [CFG_W-1:0] x_min;
    logic [CFG_W-1:0] x_max;
    logic [CFG_W-1:0] y_min;
    logic [CFG_W-1:0] y_max;
    logic [CFG_W-1:0] fb_w;
    logic [CFG_W-1:0] fb_h;
    logic [CFG_W-1:0] orient;
  } calib_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  int fail_count;
  int pending_cnt;
  int checked_cnt;
  int span_err_cnt;
  int n_sent     = 0;
  int n_settings = 0;
  bit want_hold  = 1'b0;
  int unsigned cycle_cnt = 0;

  tct_in_if  in_ch ();
  tct_out_if out_ch ();

  touch_coordinate_transform_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  touch_pos_checker u_pos_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count   (fail_count),
    .pending_cnt  (pending_cnt),
    .checked_cnt  (checked_cnt),
    .span_err_cnt (span_err_cnt)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [RAW_W-1:0] rand_raw();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  // span of one axis: typical, random, reversed, field extremes or zero
  function automatic void rand_span(output int lo, output int hi);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        lo = int'($urandom_range(0, 600)) - 300;
        hi = 3400 + int'($urandom_range(0, 1000));
      end
      5, 6: begin
        lo = int'($urandom_range(0, 16383)) - 8192;
        hi = int'($urandom_range(0, 16383)) - 8192;
      end
      7: begin
        lo = 3600 + int'($urandom_range(0, 500));
        hi = int'($urandom_range(0, 400)) - 200;
      end
      8: begin
        lo = $urandom_range(0, 1) ? -8192 : 8191;
        hi = $urandom_range(0, 1) ? -8192 : 8191;
      end
      default: begin
        lo = int'($urandom_range(0, 16383)) - 8192;
        hi = lo;
      end
    endcase
  endfunction

  // framebuffer size, including empty and oversized values
  function automatic int rand_fb();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return 1;
    if (r == 2) return $urandom_range(4097, 8191);
    if (r == 3) return 4096;
    return $urandom_range(1, 4096);
  endfunction

  function automatic calib_t make_calib(int xl, int xh, int yl, int yh, int fw, int fh,
                                        int ori);
    calib_t c;
    c.x_min  = CFG_W'(xl);
    c.x_max  = CFG_W'(xh);
    c.y_min  = CFG_W'(yl);
    c.y_max  = CFG_W'(yh);
    c.fb_w   = CFG_W'(fw);
    c.fb_h   = CFG_W'(fh);
    c.orient = CFG_W'(ori);
    return c;
  endfunction

  // Offer one sample and hold it until the beat is taken.
  task automatic push_sample(input logic [RAW_W-1:0] x, input logic [RAW_W-1:0] y);
    in_ch.valid <= 1'b1;
    in_ch.raw_x <= x;
    in_ch.raw_y <= y;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
  endtask

  task automatic pause_input(input int cycles);
    if (cycles > 0) begin
      in_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic drain_pipeline();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
  endtask

  task automatic write_word(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Write the whole register set while the core is empty.
  task automatic load_calib(input calib_t c);
    drain_pipeline();
    write_word(REG_X_MIN, c.x_min);
    write_word(REG_X_MAX, c.x_max);
    write_word(REG_Y_MIN, c.y_min);
    write_word(REG_Y_MAX, c.y_max);
    write_word(REG_FB_WIDTH, c.fb_w);
    write_word(REG_FB_HEIGHT, c.fb_h);
    write_word(REG_ORIENT, c.orient);
    write_word(REG_SPARE, CFG_W'($urandom));
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Result side: random ready runs and gaps, plus one long hold-off.
  initial begin : result_sink
    int run_len;
    int gap_len;
    int i;
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (want_hold && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 6);
      out_ch.ready <= 1'b1;
      i = 0;
      do begin
        @(posedge clk);
        i++;
      end while (i < run_len && !(want_hold && !held));
      gap_len = pick_gap();
      if (gap_len > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    calib_t cal;
    int     lo_x, hi_x, lo_y, hi_y;
    int     n_items;
    bit     steady;

    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    in_ch.valid <= 1'b0;
    in_ch.raw_x <= '0;
    in_ch.raw_y <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset calibration: corners and a midpoint
    push_sample('0, '0);
    push_sample('1, '1);
    push_sample('0, '1);
    push_sample('1, '0);
    push_sample(12'd2048, 12'd1024);

    // every rotate and flip combination on an asymmetric span
    for (int ori = 0; ori < 8; ori++) begin
      load_calib(make_calib(100, 3900, 200, 3800, 800, 480, ori));
      push_sample(12'd150, 12'd3700);
    end

    // zero span on x, then on y
    load_calib(make_calib(1000, 1000, 0, 4095, 800, 480, 0));
    push_sample('1, '0);
    load_calib(make_calib(0, 4095, -5, -5, 800, 480, 0));
    push_sample(12'd7, 12'd9);

    // field extremes: full spans with y reversed, widest and empty framebuffer
    load_calib(make_calib(-8192, 8191, 8191, -8192, 8191, 0, 7));
    push_sample('0, '0);
    push_sample('1, '1);

    // one-count span with the largest nominal framebuffer
    load_calib(make_calib(0, 1, 0, 1, 4096, 4096, 0));
    push_sample(12'd1, 12'd0);
    push_sample('1, '1);

    // random calibrations, each with a batch of random samples
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      rand_span(lo_x, hi_x);
      rand_span(lo_y, hi_y);
      cal = make_calib(lo_x, hi_x, lo_y, hi_y, rand_fb(), rand_fb(), 0);
      cal.fb_w[CFG_W-1] = 1'($urandom_range(0, 1));
      cal.fb_h[CFG_W-1] = 1'($urandom_range(0, 1));
      cal.orient        = CFG_W'($urandom);
      load_calib(cal);
      steady  = (ph == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
      n_items = (ph == HOLD_PHASE) ? HOLD_ITEMS : PHASE_ITEMS;
      // keep offering while the result side is held off
      if (ph == HOLD_PHASE) want_hold = 1'b1;
      for (int i = 0; i < n_items; i++) begin
        push_sample(rand_raw(), rand_raw());
        if (!steady) pause_input(pick_gap());
      end
    end

    drain_pipeline();
    repeat (4 * PIPE_LATENCY) @(posedge clk);

    $display("Sent %0d samples over %0d register settings plus reset values",
             n_sent, n_settings);
    $display("Checked %0d results, %0d of them with a zero span", checked_cnt, span_err_cnt);
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
